>>> rtl/hsga_pkg.sv
// shared types and constants for the hyperplane split gain accumulator
// used by hsga_score and hyperplane_split_gain_accumulator; no dependencies
package hsga_pkg;

	localparam int MAX_CLASSES = 16;
	localparam int MAX_PROJ    = 8;
	localparam int CLS_W       = $clog2(MAX_CLASSES);
	localparam int PROJ_W      = $clog2(MAX_PROJ);
	localparam int THR_W       = 34;
	localparam int CFG_IDX_W   = 2;
	localparam int HIST_W      = 32;
	localparam int LG_W        = 22;
	localparam int GAIN_W      = 20;

	// function codes of an input transaction
	localparam logic [1:0] FUNC_FEATURE = 2'd0;
	localparam logic [1:0] FUNC_CLEAR   = 2'd1;
	localparam logic [1:0] FUNC_SCORE   = 2'd2;
	localparam logic [1:0] FUNC_LOAD    = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROJ_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 2'd2;

	// result kinds
	localparam logic KIND_DECISION = 1'b0;
	localparam logic KIND_SCORE    = 1'b1;

	localparam logic signed [15:0] WEIGHT_ONE = 16'sd16384;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [15:0] feature_value;
		logic [3:0]         label;
		logic [15:0]        sample_weight;
		logic [2:0]         weight_slot;
		logic signed [15:0] weight_value;
	} in_t;

	typedef struct packed {
		logic              kind;
		logic              decision;
		logic [GAIN_W-1:0] gain;
		logic              status;
	} out_t;

	typedef struct packed {
		logic              go;
		logic [4:0]        classes;
		logic [HIST_W-1:0] tot_true;
		logic [HIST_W-1:0] tot_false;
	} sc_ctl_t;

	typedef struct packed {
		logic              done;
		logic [GAIN_W-1:0] gain;
	} sc_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACC,
		ST_HWR,
		ST_SCORE
	} state_t;

	typedef enum logic [3:0] {
		SC_IDLE,
		SC_LGI,
		SC_LGN,
		SC_LGS,
		SC_POST,
		SC_MUL,
		SC_ACC,
		SC_RD,
		SC_CAP,
		SC_DIFF,
		SC_SAT,
		SC_DIV,
		SC_DONE
	} sc_state_t;

	typedef enum logic [3:0] {
		STEP_PRE_T,
		STEP_PRE_TT,
		STEP_PRE_FT,
		STEP_TLT,
		STEP_FLF,
		STEP_NLN,
		STEP_NLT,
		STEP_TLTT,
		STEP_FLFT
	} sc_step_t;

endpackage

>>> rtl/hsga_score.sv
// score engine: walks the class histograms and computes information gain
// depends on hsga_pkg; histogram memory lives in the top level
module hsga_score import hsga_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  sc_ctl_t           ctl,
	output sc_rsp_t           rsp,
	output logic [CLS_W-1:0]  rd_addr,
	input  logic [2*HIST_W-1:0] rd_data
);

	sc_state_t state_q, state_nx;
	sc_step_t  step_q;

	logic [4:0]        cls_q;
	logic [4:0]        classes_q;
	logic [HIST_W:0]   tot_q;
	logic [HIST_W-1:0] tt_q, ft_q, t_q, f_q;
	logic [HIST_W:0]   n_q;
	logic [LG_W-1:0]   lgt_q, lgtt_q, lgft_q, lg_q;
	logic [HIST_W:0]   m_q;
	logic [5:0]        e_q;
	logic [31:0]       mant_q;
	logic [15:0]       frac_q;
	logic [3:0]        sq_cnt_q;
	logic [HIST_W+LG_W:0] prod_q;
	logic [63:0]       p_q, nacc_q, diff_q;
	logic              pos_q;
	logic [52:0]       rem_q, dv_q;
	logic [GAIN_W-1:0] quo_q, gain_q;
	logic [4:0]        div_cnt_q;

	logic [HIST_W:0]   opnd;
	logic [HIST_W:0]   ctl_tot;
	logic              use_stored, is_pre, to_p;
	logic [LG_W-1:0]   stored_lg;
	logic [63:0]       sq;
	logic [32:0]       sq_sh;
	logic              ge;

	assign ctl_tot = {1'b0, ctl.tot_true} + {1'b0, ctl.tot_false};
	assign rd_addr = cls_q[CLS_W-1:0];
	assign sq      = {32'd0, mant_q} * {32'd0, mant_q};
	assign sq_sh   = sq[63:31];
	assign ge      = rem_q >= dv_q;

	// operand and routing of each step
	always_comb begin
		opnd       = tot_q;
		use_stored = 1'b0;
		is_pre     = 1'b0;
		to_p       = 1'b0;
		stored_lg  = lgt_q;
		case (step_q)
			STEP_PRE_T: begin
				opnd = tot_q;
				is_pre = 1'b1;
			end
			STEP_PRE_TT: begin
				opnd = {1'b0, tt_q};
				is_pre = 1'b1;
			end
			STEP_PRE_FT: begin
				opnd = {1'b0, ft_q};
				is_pre = 1'b1;
			end
			STEP_TLT: begin
				opnd = {1'b0, t_q};
				to_p = 1'b1;
			end
			STEP_FLF: begin
				opnd = {1'b0, f_q};
				to_p = 1'b1;
			end
			STEP_NLN: begin
				opnd = n_q;
			end
			STEP_NLT: begin
				opnd = n_q;
				to_p = 1'b1;
				use_stored = 1'b1;
				stored_lg = lgt_q;
			end
			STEP_TLTT: begin
				opnd = {1'b0, t_q};
				use_stored = 1'b1;
				stored_lg = lgtt_q;
			end
			STEP_FLFT: begin
				opnd = {1'b0, f_q};
				use_stored = 1'b1;
				stored_lg = lgft_q;
			end
			default: begin
				opnd = tot_q;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			SC_IDLE: begin
				if (ctl.go) state_nx = (ctl_tot == '0) ? SC_DONE : SC_LGI;
			end
			SC_LGI: begin
				if (use_stored) state_nx = SC_MUL;
				else if (opnd == '0) state_nx = SC_POST;
				else state_nx = SC_LGN;
			end
			SC_LGN: begin
				if (m_q[HIST_W]) state_nx = SC_LGS;
			end
			SC_LGS: begin
				if (sq_cnt_q == 4'd15) state_nx = SC_POST;
			end
			SC_POST: begin
				if (is_pre) state_nx = (step_q == STEP_PRE_FT) ? SC_RD : SC_LGI;
				else state_nx = SC_MUL;
			end
			SC_MUL: state_nx = SC_ACC;
			SC_ACC: begin
				if (step_q == STEP_FLFT) begin
					state_nx = (cls_q + 5'd1 == classes_q) ? SC_DIFF : SC_RD;
				end else begin
					state_nx = SC_LGI;
				end
			end
			SC_RD: state_nx = SC_CAP;
			SC_CAP: state_nx = SC_LGI;
			SC_DIFF: state_nx = SC_SAT;
			SC_SAT: begin
				if (!pos_q || diff_q >= {11'd0, tot_q, 20'd0}) state_nx = SC_DONE;
				else state_nx = SC_DIV;
			end
			SC_DIV: begin
				if (div_cnt_q == 5'd19) state_nx = SC_DONE;
			end
			SC_DONE: state_nx = SC_IDLE;
			default: state_nx = SC_IDLE;
		endcase
	end

	// step and class counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_PRE_T;
			cls_q  <= '0;
		end else begin
			priority case (1'b1)
				state_q == SC_IDLE: begin
					step_q <= STEP_PRE_T;
					cls_q  <= '0;
				end
				state_q == SC_POST && is_pre: begin
					if (step_q == STEP_PRE_T) step_q <= STEP_PRE_TT;
					else if (step_q == STEP_PRE_TT) step_q <= STEP_PRE_FT;
				end
				state_q == SC_CAP: step_q <= STEP_TLT;
				state_q == SC_ACC: begin
					case (step_q)
						STEP_TLT:  step_q <= STEP_FLF;
						STEP_FLF:  step_q <= STEP_NLN;
						STEP_NLN:  step_q <= STEP_NLT;
						STEP_NLT:  step_q <= STEP_TLTT;
						STEP_TLTT: step_q <= STEP_FLFT;
						default:   cls_q  <= cls_q + 5'd1;
					endcase
				end
				default: step_q <= step_q;
			endcase
		end
	end

	// datapath: log unit, product, accumulators, divider
	always_ff @(posedge clk) begin
		unique case (state_q)
			SC_IDLE: begin
				tt_q      <= ctl.tot_true;
				ft_q      <= ctl.tot_false;
				tot_q     <= ctl_tot;
				classes_q <= ctl.classes;
				p_q       <= '0;
				nacc_q    <= '0;
				gain_q    <= '0;
			end
			SC_LGI: begin
				if (use_stored) lg_q <= stored_lg;
				else lg_q <= '0;
				m_q <= opnd;
				e_q <= 6'd32;
			end
			SC_LGN: begin
				if (m_q[HIST_W]) begin
					mant_q   <= m_q[HIST_W:1];
					frac_q   <= '0;
					sq_cnt_q <= '0;
				end else begin
					m_q <= {m_q[HIST_W-1:0], 1'b0};
					e_q <= e_q - 6'd1;
				end
			end
			SC_LGS: begin
				// one square per cycle, each yields one fraction bit
				mant_q   <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
				frac_q   <= {frac_q[14:0], sq_sh[32]};
				sq_cnt_q <= sq_cnt_q + 4'd1;
				if (sq_cnt_q == 4'd15) lg_q <= {e_q, frac_q[14:0], sq_sh[32]};
			end
			SC_POST: begin
				if (step_q == STEP_PRE_T) lgt_q <= lg_q;
				if (step_q == STEP_PRE_TT) lgtt_q <= lg_q;
				if (step_q == STEP_PRE_FT) lgft_q <= lg_q;
			end
			SC_MUL: begin
				prod_q <= {{(LG_W){1'b0}}, opnd} * {{(HIST_W+1){1'b0}}, lg_q};
			end
			SC_ACC: begin
				if (to_p) p_q <= p_q + {9'd0, prod_q};
				else nacc_q <= nacc_q + {9'd0, prod_q};
			end
			SC_RD: begin
				pos_q <= 1'b0;
			end
			SC_CAP: begin
				t_q <= rd_data[2*HIST_W-1:HIST_W];
				f_q <= rd_data[HIST_W-1:0];
				n_q <= {1'b0, rd_data[2*HIST_W-1:HIST_W]} + {1'b0, rd_data[HIST_W-1:0]};
			end
			SC_DIFF: begin
				diff_q <= p_q - nacc_q;
				pos_q  <= p_q > nacc_q;
			end
			SC_SAT: begin
				if (!pos_q) gain_q <= '0;
				else gain_q <= '1;
				rem_q     <= diff_q[52:0];
				dv_q      <= {1'b0, tot_q, 19'd0};
				quo_q     <= '0;
				div_cnt_q <= '0;
			end
			SC_DIV: begin
				// restoring division, one quotient bit per cycle
				if (ge) rem_q <= rem_q - dv_q;
				dv_q      <= {1'b0, dv_q[52:1]};
				quo_q     <= {quo_q[GAIN_W-2:0], ge};
				div_cnt_q <= div_cnt_q + 5'd1;
				if (div_cnt_q == 5'd19) gain_q <= {quo_q[GAIN_W-2:0], ge};
			end
			SC_DONE: begin
				pos_q <= 1'b0;
			end
			default: begin
				pos_q <= 1'b0;
			end
		endcase
	end

	assign rsp.done = state_q == SC_DONE;
	assign rsp.gain = gain_q;

endmodule

>>> rtl/hyperplane_split_gain_accumulator.sv
// hyperplane split test with class histograms and information gain scoring
// depends on hsga_pkg and hsga_score
// a non-final feature element returns to idle after the sum stage; a final element
// strobes its decision after the sum stage and the histogram memory read-modify-write
// (after the sum stage alone when the label is out of range); clear and load finish in idle
// a score takes 3 log steps, then per class a read, 3 log steps each with a product
// and 3 products of stored logs, then a divide unless the gain is zero or saturates;
// results cannot be stalled; reset clears statistics, weights to 1.0
module hyperplane_split_gain_accumulator import hsga_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  in_t                  cmd,
	output logic                 strobe,
	output out_t                 result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]     cfg_data
);

	state_t state_q, state_nx;

	logic signed [THR_W-1:0] threshold_q;
	logic [3:0]              proj_count_q;
	logic [4:0]              class_count_q;
	logic signed [15:0]      wt_q [MAX_PROJ];
	logic signed [THR_W-1:0] sum_q;
	logic [PROJ_W-1:0]       cnt_q;
	logic [HIST_W-1:0]       tot_true_q, tot_false_q;
	logic [MAX_CLASSES-1:0]  hist_vld_q;
	logic [2*HIST_W-1:0]     hist_mem [MAX_CLASSES];
	logic [2*HIST_W-1:0]     hist_rd_q;
	logic                    rd_vld_q;
	logic signed [31:0]      prod_s1;
	logic [3:0]              label_q;
	logic [15:0]             sw_q;
	logic                    dec_q;
	logic                    strobe_q;
	out_t                    result_q;

	logic                    accept;
	logic [3:0]              eff_proj;
	logic [4:0]              eff_cls;
	logic signed [THR_W:0]   sum_wide;
	logic signed [THR_W-1:0] sum_nx;
	logic                    last_el, bad_lbl, dec_nx;
	logic [CLS_W-1:0]        rd_addr, sc_addr;
	logic [2*HIST_W-1:0]     hist_rd;
	logic [HIST_W:0]         t_add, f_add;
	logic [HIST_W-1:0]       t_sat, f_sat;
	sc_ctl_t                 sc_ctl;
	sc_rsp_t                 sc_rsp;

	assign accept    = start && !busy;
	assign busy      = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign strobe    = strobe_q;
	assign result    = result_q;

	// effective counts
	always_comb begin
		if (proj_count_q == 4'd0) eff_proj = 4'd1;
		else if (proj_count_q > 4'(MAX_PROJ)) eff_proj = 4'(MAX_PROJ);
		else eff_proj = proj_count_q;
		if (class_count_q == 5'd0) eff_cls = 5'd1;
		else if (class_count_q > 5'(MAX_CLASSES)) eff_cls = 5'(MAX_CLASSES);
		else eff_cls = class_count_q;
	end

	// saturating projection sum and decision
	always_comb begin
		sum_wide = {sum_q[THR_W-1], sum_q} + {{(THR_W-31){prod_s1[31]}}, prod_s1};
		if (sum_wide[THR_W] != sum_wide[THR_W-1]) begin
			sum_nx = sum_wide[THR_W] ? {1'b1, {(THR_W-1){1'b0}}} : {1'b0, {(THR_W-1){1'b1}}};
		end else begin
			sum_nx = sum_wide[THR_W-1:0];
		end
		last_el = ({1'b0, cnt_q} + 4'd1) >= eff_proj;
		dec_nx  = sum_nx > threshold_q;
		bad_lbl = {1'b0, label_q} >= eff_cls;
	end

	// histogram read data and saturating update
	assign hist_rd = rd_vld_q ? hist_rd_q : '0;
	assign t_add   = {1'b0, hist_rd[2*HIST_W-1:HIST_W]} + {17'd0, sw_q};
	assign f_add   = {1'b0, hist_rd[HIST_W-1:0]} + {17'd0, sw_q};
	assign t_sat   = t_add[HIST_W] ? '1 : t_add[HIST_W-1:0];
	assign f_sat   = f_add[HIST_W] ? '1 : f_add[HIST_W-1:0];
	assign rd_addr = (state_q == ST_SCORE) ? sc_addr : label_q;

	// score engine
	assign sc_ctl.go        = accept && cmd.func == FUNC_SCORE;
	assign sc_ctl.classes   = eff_cls;
	assign sc_ctl.tot_true  = tot_true_q;
	assign sc_ctl.tot_false = tot_false_q;

	hsga_score u_score (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (sc_ctl),
		.rsp     (sc_rsp),
		.rd_addr (sc_addr),
		.rd_data (hist_rd)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd.func == FUNC_FEATURE) state_nx = ST_ACC;
				else if (accept && cmd.func == FUNC_SCORE) state_nx = ST_SCORE;
			end
			ST_ACC: state_nx = (last_el && !bad_lbl) ? ST_HWR : ST_IDLE;
			ST_HWR: state_nx = ST_IDLE;
			ST_SCORE: begin
				if (sc_rsp.done) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// histogram memory, one read and one write port
	always_ff @(posedge clk) begin
		hist_rd_q <= hist_mem[rd_addr];
		rd_vld_q  <= hist_vld_q[rd_addr];
		if (state_q == ST_HWR) begin
			hist_mem[label_q] <= dec_q ? {t_sat, hist_rd[HIST_W-1:0]}
				: {hist_rd[2*HIST_W-1:HIST_W], f_sat};
		end
	end

	// input capture and product
	always_ff @(posedge clk) begin
		if (accept && cmd.func == FUNC_FEATURE) begin
			prod_s1 <= 32'(cmd.feature_value) * 32'(wt_q[cnt_q]);
			label_q <= cmd.label;
			sw_q    <= cmd.sample_weight;
		end
		if (state_q == ST_ACC) dec_q <= dec_nx;
		if (state_q == ST_ACC) begin
			result_q.kind     <= KIND_DECISION;
			result_q.decision <= dec_nx;
			result_q.gain     <= '0;
			result_q.status   <= bad_lbl;
		end else if (state_q == ST_SCORE) begin
			result_q.kind     <= KIND_SCORE;
			result_q.decision <= 1'b0;
			result_q.gain     <= sc_rsp.gain;
			result_q.status   <= 1'b0;
		end
	end

	// configuration, weights, sums and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q   <= '0;
			proj_count_q  <= 4'd1;
			class_count_q <= 5'd2;
			for (int i = 0; i < MAX_PROJ; i++) wt_q[i] <= WEIGHT_ONE;
			sum_q         <= '0;
			cnt_q         <= '0;
			tot_true_q    <= '0;
			tot_false_q   <= '0;
			hist_vld_q    <= '0;
			strobe_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_THRESHOLD) threshold_q <= cfg_data;
				if (cfg_index == CFG_PROJ_COUNT) proj_count_q <= cfg_data[3:0];
				if (cfg_index == CFG_CLASS_COUNT) class_count_q <= cfg_data[4:0];
			end
			if (accept && cmd.func == FUNC_CLEAR) begin
				hist_vld_q  <= '0;
				tot_true_q  <= '0;
				tot_false_q <= '0;
			end
			if (accept && cmd.func == FUNC_LOAD) begin
				wt_q[cmd.weight_slot] <= cmd.weight_value;
			end
			unique case (state_q)
				ST_ACC: begin
					if (last_el) begin
						sum_q <= '0;
						cnt_q <= '0;
						strobe_q <= bad_lbl;
					end else begin
						sum_q <= sum_nx;
						cnt_q <= cnt_q + 1'b1;
						strobe_q <= 1'b0;
					end
				end
				ST_HWR: begin
					strobe_q <= 1'b1;
					hist_vld_q[label_q] <= 1'b1;
					if (dec_q) tot_true_q <= (({1'b0, tot_true_q} + {17'd0, sw_q}) > {1'b0, {HIST_W{1'b1}}})
						? '1 : tot_true_q + {16'd0, sw_q};
					else tot_false_q <= (({1'b0, tot_false_q} + {17'd0, sw_q}) > {1'b0, {HIST_W{1'b1}}})
						? '1 : tot_false_q + {16'd0, sw_q};
				end
				ST_SCORE: begin
					strobe_q <= sc_rsp.done;
				end
				default: begin
					strobe_q <= 1'b0;
				end
			endcase
		end
	end

	// results are never back to back
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("two results in consecutive cycles");

	// histogram write only follows the sum stage
	a_hwr_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HWR |-> $past(state_q) == ST_ACC) else $error("histogram write out of order");

	// a score result carries no decision or status
	a_score_fields: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.kind == KIND_SCORE |-> !result.decision && !result.status)
		else $error("score result with decision fields");

	// score engine answers only while a score is pending
	a_score_done: assert property (@(posedge clk) disable iff (!arst_n)
		sc_rsp.done |-> state_q == ST_SCORE) else $error("unexpected score completion");

endmodule
